@@ hdl/ntmt_pkg.sv @@
// ----------------------------------------------------------------------------
// ntmt_pkg
// Shared constants and types for the neighbour traffic monitor table.
// ----------------------------------------------------------------------------
package ntmt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int COUNT_BITS  = 16;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

  // result field widths
  localparam int OUT_CNT_W = 16;
  localparam int OUT_IDX_W = 4;

  // packet kinds
  localparam logic [2:0] KIND_ROUTE_REQ = 3'd0;
  localparam logic [2:0] KIND_ROUTE_REP = 3'd1;
  localparam logic [2:0] KIND_DATA      = 3'd2;
  localparam logic [2:0] KIND_ACK       = 3'd3;
  localparam logic [2:0] KIND_IGNORED   = 3'd4;

  // counter fields within one table row
  localparam int NUM_CNT = 5;
  localparam logic [2:0] FLD_REQ   = 3'd0;
  localparam logic [2:0] FLD_REP   = 3'd1;
  localparam logic [2:0] FLD_OWN   = 3'd2;
  localparam logic [2:0] FLD_RELAY = 3'd3;
  localparam logic [2:0] FLD_ACK   = 3'd4;
  localparam logic [2:0] FLD_NONE  = 3'd5;

  typedef logic [COUNT_BITS-1:0]             count_t;
  typedef logic [NUM_CNT-1:0][COUNT_BITS-1:0] cnt_row_t;

endpackage

@@ hdl/neighbor_traffic_monitor_table.sv @@
// ----------------------------------------------------------------------------
// neighbor_traffic_monitor_table
// Per-neighbour traffic statistics, keyed by the forwarding node's ID.
// ----------------------------------------------------------------------------
// Pulse start with a packet header while busy is low. Join/control/status
// packets give a result on out_valid in the next cycle. Any other packet runs
// a linear search of the key memory, one entry per cycle, then one
// read-modify-write of the counter row through a single shared incrementer.
// The search steps once per entry compared, plus once more when the forwarder
// is missing; a match or a new slot then goes through the update state, while
// a drop on a full table skips the update. For a searched packet, busy is
// high from the transfer until the cycle in which the result appears, so the
// next packet can be taken in that cycle. Each result is presented for exactly
// one cycle on out_valid and cannot be held off, so it must be captured when
// it appears.
// The table starts empty; when all 16 slots are taken a new forwarder is
// reported with out_table_full and dropped.
// ----------------------------------------------------------------------------
module neighbor_traffic_monitor_table
  import ntmt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // command side
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_packet_kind,
  input  logic [7:0]           in_forwarder_id,
  input  logic [7:0]           in_origin_id,
  input  logic [7:0]           in_signal_strength,
  input  logic [31:0]          in_now_tick,
  // result side
  output logic                 out_valid,
  output logic                 out_ignored,
  output logic                 out_table_full,
  output logic                 out_new_entry,
  output logic [OUT_IDX_W-1:0] out_entry_index,
  output logic [OUT_CNT_W-1:0] out_route_request_count,
  output logic [OUT_CNT_W-1:0] out_route_reply_count,
  output logic [OUT_CNT_W-1:0] out_own_data_count,
  output logic [OUT_CNT_W-1:0] out_relayed_data_count,
  output logic [OUT_CNT_W-1:0] out_ack_count
);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  // storage
  logic [7:0]  key_mem  [TABLE_DEPTH];
  cnt_row_t    cnt_mem  [TABLE_DEPTH];
  logic [39:0] seen_mem [TABLE_DEPTH];

  // control
  logic [1:0]      state_r, state_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [USED_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic            created_r, created_nxt;
  logic            out_valid_r, out_valid_nxt;

  // latched header
  logic [7:0]  fwd_r;
  logic [7:0]  rss_r;
  logic [31:0] tick_r;
  logic [2:0]  fld_r;

  // registered memory reads
  logic [7:0] key_rd_r;
  cnt_row_t   cnt_rd_r;

  // result registers
  logic                 ignored_r, full_r, new_r;
  logic [OUT_IDX_W-1:0] index_r;
  cnt_row_t             res_row_r;

  logic     accept;
  logic [2:0] fld_in;
  cnt_row_t base_row, upd_row;
  count_t   inc_in, inc_out;
  logic     load_ign, load_full, load_upd;

  assign accept = start && (state_r == S_IDLE);

  // counter field chosen by the packet kind
  always_comb begin
    case (in_packet_kind)
      KIND_ROUTE_REQ: fld_in = FLD_REQ;
      KIND_ROUTE_REP: fld_in = FLD_REP;
      KIND_DATA:      fld_in = (in_origin_id == in_forwarder_id) ? FLD_OWN : FLD_RELAY;
      KIND_ACK:       fld_in = FLD_ACK;
      default:        fld_in = FLD_NONE;
    endcase
  end

  // shared incrementer on the selected row field
  always_comb begin
    base_row = created_r ? '0 : cnt_rd_r;
    upd_row  = base_row;
    inc_in   = '0;
    if (fld_r < FLD_NONE) begin
      inc_in = base_row[fld_r];
      upd_row[fld_r] = inc_out;
    end
  end
  assign inc_out = inc_in + count_t'(1);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    created_nxt   = created_r;
    out_valid_nxt = 1'b0;
    load_ign      = 1'b0;
    load_full     = 1'b0;
    load_upd      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_packet_kind == KIND_IGNORED) begin
            load_ign      = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (idx_r >= used_r) begin
          // forwarder not in table
          if (used_r == USED_W'(TABLE_DEPTH)) begin
            load_full     = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            slot_nxt    = used_r[SLOT_W-1:0];
            created_nxt = 1'b1;
            state_nxt   = S_UPDATE;
          end
        end else if (key_rd_r == fwd_r) begin
          slot_nxt    = idx_r[SLOT_W-1:0];
          created_nxt = 1'b0;
          state_nxt   = S_UPDATE;
        end else begin
          idx_nxt = idx_r + USED_W'(1);
        end
      end
      S_UPDATE: begin
        load_upd      = 1'b1;
        out_valid_nxt = 1'b1;
        if (created_r) begin
          used_nxt = used_r + USED_W'(1);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    slot_r    <= slot_nxt;
    created_r <= created_nxt;
    if (accept) begin
      fwd_r  <= in_forwarder_id;
      rss_r  <= in_signal_strength;
      tick_r <= in_now_tick;
      fld_r  <= fld_in;
    end
  end

  // key memory: search read, write on creation
  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[idx_nxt[SLOT_W-1:0]];
    if (load_upd && created_r) begin
      key_mem[slot_r] <= fwd_r;
    end
  end

  // counter row memory: read at the matched slot, written back on update
  always_ff @(posedge clk) begin
    cnt_rd_r <= cnt_mem[slot_nxt];
    if (load_upd) begin
      cnt_mem[slot_r] <= upd_row;
    end
  end

  // last-seen time and strength
  always_ff @(posedge clk) begin
    if (load_upd) begin
      seen_mem[slot_r] <= {tick_r, rss_r};
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (load_ign || load_full) begin
      ignored_r <= load_ign;
      full_r    <= load_full;
      new_r     <= 1'b0;
      index_r   <= '0;
      res_row_r <= '0;
    end else if (load_upd) begin
      ignored_r <= 1'b0;
      full_r    <= 1'b0;
      new_r     <= created_r;
      index_r   <= OUT_IDX_W'(slot_r);
      res_row_r <= upd_row;
    end
  end

  assign busy                    = (state_r != S_IDLE);
  assign out_valid               = out_valid_r;
  assign out_ignored             = ignored_r;
  assign out_table_full          = full_r;
  assign out_new_entry           = new_r;
  assign out_entry_index         = index_r;
  assign out_route_request_count = OUT_CNT_W'(res_row_r[FLD_REQ]);
  assign out_route_reply_count   = OUT_CNT_W'(res_row_r[FLD_REP]);
  assign out_own_data_count      = OUT_CNT_W'(res_row_r[FLD_OWN]);
  assign out_relayed_data_count  = OUT_CNT_W'(res_row_r[FLD_RELAY]);
  assign out_ack_count           = OUT_CNT_W'(res_row_r[FLD_ACK]);

  // checks
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({ignored_r, full_r, new_r}))
    else $error("result flags not exclusive");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && full_r) |-> (used_r == USED_W'(TABLE_DEPTH)))
    else $error("table full reported with free slots");

  a_ignore_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_packet_kind == KIND_IGNORED) |=> (out_valid_r && ignored_r))
    else $error("ignored packet gave no immediate result");

  a_create_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE && created_r) |=> (used_r == $past(used_r) + USED_W'(1)))
    else $error("new entry did not advance the entry count");

endmodule
